// ===== rtl/tmc_pkg.sv =====
// shared types and constants of the three-channel moving average
package tmc_pkg;

    localparam int CHANNEL_COUNT = 3;
    localparam int CH_BITS       = $clog2(CHANNEL_COUNT);

    typedef logic [CH_BITS-1:0] t_ch;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ===== rtl/tmc_ram.sv =====
// generic simple dual-port ram with registered read
module tmc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/tmc_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module tmc_div #(
    parameter int SUM_W = 16,
    parameter int DIV_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quotient
);

    localparam int CW = $clog2(SUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dvs;

    logic [DIV_W:0]   w_part;
    logic [DIV_W:0]   w_diff;
    logic             w_fits;
    logic [DIV_W-1:0] n_rem;
    logic [SUM_W-1:0] n_quo;

    always_comb begin
        w_part = {r_rem, r_quo[SUM_W-1]};
        w_diff = w_part - {1'b0, r_dvs};
        w_fits = (w_part >= {1'b0, r_dvs});
        n_rem  = w_fits ? w_diff[DIV_W-1:0] : w_part[DIV_W-1:0];
        n_quo  = {r_quo[SUM_W-2:0], w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/three_channel_moving_average.sv =====
// three-channel moving average: top level with sequencer, sums and window ram
//
//  channel   handshake           payload
//  input     i_valid / o_ready   i_sample_ch0..2
//  output    o_valid / i_ready   o_average_ch0..2, o_window_full
//
// one scan runs each channel through the bit-serial divider, which is
// shared by the three channels in turn
// o_ready is high only while the sequencer is idle
// the output register holds one result, so a stalled output lets the next
// scan be taken and worked on; it then waits in its last state for room
// reset clears sums, write position and window-full flag; the ram is not cleared
module three_channel_moving_average #(
    parameter int WINDOW_LENGTH = 16,
    parameter int SAMPLE_BITS   = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample_ch0,
    input  logic [SAMPLE_BITS-1:0] i_sample_ch1,
    input  logic [SAMPLE_BITS-1:0] i_sample_ch2,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_average_ch0,
    output logic [SAMPLE_BITS-1:0] o_average_ch1,
    output logic [SAMPLE_BITS-1:0] o_average_ch2,
    output logic                   o_window_full
);

    import tmc_pkg::*;

    localparam int PB     = $clog2(WINDOW_LENGTH);
    localparam int DW     = $clog2(WINDOW_LENGTH + 1);
    localparam int SUM_W  = SAMPLE_BITS + PB;
    localparam int AW     = CH_BITS + PB;
    localparam int DEPTH  = 1 << AW;

    t_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] r_samp  [CHANNEL_COUNT];
    logic [SUM_W-1:0]       r_sum   [CHANNEL_COUNT];
    logic [SAMPLE_BITS-1:0] r_avg   [CHANNEL_COUNT];
    logic [SAMPLE_BITS-1:0] r_o_avg [CHANNEL_COUNT];
    logic [PB-1:0]          r_pos;
    logic                   r_filled;
    logic                   r_o_valid;
    logic                   r_o_full;
    t_ch                    r_ch;

    logic                   w_accept;
    logic                   w_last_slot;
    logic [PB-1:0]          w_next_pos;
    logic                   w_now_full;
    logic [DW-1:0]          w_divisor;
    logic [AW-1:0]          w_addr;
    logic [SAMPLE_BITS-1:0] w_rd_data;
    logic [SAMPLE_BITS-1:0] w_old;
    logic [SUM_W-1:0]       w_sum_new;
    logic                   w_rd_en;
    logic                   w_wr_en;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [SUM_W-1:0]       w_quotient;
    logic                   w_out_load;
    logic                   w_ch_last;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        w_last_slot = (r_pos == PB'(WINDOW_LENGTH - 1));
        w_next_pos  = w_last_slot ? '0 : r_pos + 1'b1;
        w_now_full  = r_filled | w_last_slot;
        w_divisor   = w_now_full ? DW'(WINDOW_LENGTH) : DW'(w_next_pos);
        w_addr      = {r_ch, r_pos};
        w_old       = r_filled ? w_rd_data : '0;
        w_sum_new   = r_sum[r_ch] - SUM_W'(w_old) + SUM_W'(r_samp[r_ch]);
        w_ch_last   = (r_ch == CH_BITS'(CHANNEL_COUNT - 1));
    end

    tmc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (r_samp[r_ch]),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    tmc_div #(
        .SUM_W (SUM_W),
        .DIV_W (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum_new),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                w_rd_en = 1'b1;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                w_wr_en     = 1'b1;
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = w_ch_last ? S_DONE : S_READ;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '{default: '0};
            r_pos     <= '0;
            r_filled  <= 1'b0;
            r_o_valid <= 1'b0;
            r_ch      <= '0;
        end else begin
            if (w_accept) begin
                r_ch <= '0;
            end
            if (r_state == S_UPDATE) begin
                r_sum[r_ch] <= w_sum_new;
            end
            if (r_state == S_DIV && w_div_done && !w_ch_last) begin
                r_ch <= r_ch + 1'b1;
            end
            if (w_out_load) begin
                r_o_valid <= 1'b1;
                r_pos     <= w_next_pos;
                r_filled  <= w_now_full;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_samp[0] <= i_sample_ch0;
            r_samp[1] <= i_sample_ch1;
            r_samp[2] <= i_sample_ch2;
        end
        if (r_state == S_DIV && w_div_done) begin
            r_avg[r_ch] <= w_quotient[SAMPLE_BITS-1:0];
        end
        if (w_out_load) begin
            r_o_avg  <= r_avg;
            r_o_full <= w_now_full;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_average_ch0 = r_o_avg[0];
    assign o_average_ch1 = r_o_avg[1];
    assign o_average_ch2 = r_o_avg[2];
    assign o_window_full = r_o_full;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_READ))
        else $error("accepted beat did not start the sequencer");

    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled |=> r_filled)
        else $error("window-full flag dropped");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> (w_divisor != '0))
        else $error("zero divisor issued to divider");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the wait state");

    a_out_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_window_full) |-> r_filled)
        else $error("output beat claims full window before flag set");

endmodule
